/* hw/rtl/scim_pkg.sv */
package scim_pkg;

  localparam int COORD_BITS = 32;
  localparam int EPS_BITS = 32;
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT = 5;

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_EPSILON   = 2'd3
  } cfg_reg_t;

endpackage

/* hw/rtl/scim_delay.sv */
module scim_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         ce,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line_r [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) begin
        line_r[k] <= '0;
      end
    end else if (ce) begin
      line_r[0] <= d;
      for (int k = 1; k < D; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign q = line_r[D-1];

endmodule

/* hw/rtl/scim_mul.sv */
module scim_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH  = scim_pkg::MUL_CHUNK;
  localparam int NA  = (AW + CH - 1) / CH;
  localparam int NB  = (BW + CH - 1) / CH;
  localparam int RWD = (NB + 1) * CH;
  localparam int TW  = (NA + NB + 1) * CH;
  localparam int PW  = AW + BW;

  logic [AW-1:0]      aabs;
  logic [BW-1:0]      babs;
  logic [NA*CH-1:0]   ma_r;
  logic [NB*CH-1:0]   mb_r;
  logic [3:0]         sg_r;
  logic [2*CH-1:0]    pp_r [NA][NB];
  logic [RWD-1:0]     row_r [NA];
  logic [RWD-1:0]     row_nxt [NA];
  logic [TW-1:0]      tot_r;
  logic [TW-1:0]      tot_nxt;
  logic signed [PW-1:0] p_r;

  assign aabs = a[AW-1] ? (~a + AW'(1)) : a;
  assign babs = b[BW-1] ? (~b + BW'(1)) : b;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RWD'(pp_r[i][j]) << (j * CH));
      end
    end
    tot_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      tot_nxt = tot_nxt + (TW'(row_r[i]) << (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ma_r <= (NA*CH)'(aabs);
      mb_r <= (NB*CH)'(babs);
      sg_r <= {sg_r[2:0], a[AW-1] ^ b[BW-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_r[i*CH +: CH] * mb_r[j*CH +: CH];
        end
      end
      row_r <= row_nxt;
      tot_r <= tot_nxt;
      p_r   <= sg_r[3] ? (~tot_r[PW-1:0] + PW'(1)) : tot_r[PW-1:0];
    end
  end

  assign p = p_r;

endmodule

/* hw/rtl/scim_isqrt.sv */
module scim_isqrt #(
  parameter int IW = 66,
  parameter int RW = (IW + 1) / 2
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [IW-1:0] x,
  output logic [RW-1:0] root
);

  localparam int XW = 2 * RW;

  logic [XW-1:0] x_r   [RW];
  logic [RW+1:0] r_r   [RW];
  logic [RW-1:0] s_r   [RW];
  logic [XW-1:0] x_nxt [RW];
  logic [RW+1:0] r_nxt [RW];
  logic [RW-1:0] s_nxt [RW];

  always_comb begin
    logic [XW-1:0] xi;
    logic [RW+1:0] ri;
    logic [RW-1:0] si;
    logic [RW+3:0] rt;
    logic [RW+3:0] trial;
    for (int k = 0; k < RW; k++) begin
      xi = (k == 0) ? XW'(x) : x_r[k-1];
      ri = (k == 0) ? '0 : r_r[k-1];
      si = (k == 0) ? '0 : s_r[k-1];
      rt = {ri, xi[XW-1 -: 2]};
      trial = {2'b00, si, 2'b01};
      x_nxt[k] = xi << 2;
      if (rt >= trial) begin
        r_nxt[k] = (RW+2)'(rt - trial);
        s_nxt[k] = {si[RW-2:0], 1'b1};
      end else begin
        r_nxt[k] = rt[RW+1:0];
        s_nxt[k] = {si[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r <= x_nxt;
      r_r <= r_nxt;
      s_r <= s_nxt;
    end
  end

  assign root = s_r[RW-1];

endmodule

/* hw/rtl/scim_div.sv */
module scim_div #(
  parameter int QW = 65
) (
  input  logic            clk,
  input  logic            ce,
  input  logic [2*QW-1:0] num,
  input  logic [QW-1:0]   den,
  output logic [QW-1:0]   quo
);

  logic [QW-1:0] rem_r   [QW];
  logic [QW-1:0] lo_r    [QW];
  logic [QW-1:0] den_r   [QW];
  logic [QW-1:0] rem_nxt [QW];
  logic [QW-1:0] lo_nxt  [QW];
  logic [QW-1:0] den_nxt [QW];

  always_comb begin
    logic [QW-1:0] ri;
    logic [QW-1:0] li;
    logic [QW-1:0] di;
    logic [QW:0]   t;
    for (int k = 0; k < QW; k++) begin
      ri = (k == 0) ? num[2*QW-1:QW] : rem_r[k-1];
      li = (k == 0) ? num[QW-1:0] : lo_r[k-1];
      di = (k == 0) ? den : den_r[k-1];
      t = {ri, li[QW-1]};
      den_nxt[k] = di;
      if (t >= {1'b0, di}) begin
        rem_nxt[k] = QW'(t - {1'b0, di});
        lo_nxt[k]  = {li[QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[QW-1:0];
        lo_nxt[k]  = {li[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      den_r <= den_nxt;
    end
  end

  assign quo = lo_r[QW-1];

endmodule

/* hw/rtl/segment_circle_intersect_unit.sv */
// Throughput is one item per cycle; the whole pipeline advances together and
// holds while a finished result waits to be taken.
// The depth is set by the two bit-per-stage square roots and the bit-per-stage divider.
// Synchronous reset (rst_n low) empties the pipeline and zeroes the config registers.
module segment_circle_intersect_unit #(
  parameter int COORD_BITS = scim_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [COORD_BITS-1:0]        out_hit_distance,
  output logic                         out_degenerate,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [((COORD_BITS > scim_pkg::EPS_BITS) ? COORD_BITS : scim_pkg::EPS_BITS)-1:0]
                                       cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int EB   = scim_pkg::EPS_BITS;
  localparam int M    = scim_pkg::MUL_LAT;
  localparam int P    = CB + 1;
  localparam int DW   = 2 * CB + 2;
  localparam int VVW  = 2 * CB + 1;
  localparam int QW   = 2 * DW;
  localparam int LS1  = QW / 2;
  localparam int NW   = 2 * CB + 4;
  localparam int LDV  = VVW;
  localparam int LS2  = (VVW + 1) / 2;
  localparam int DR   = 6 + 3 * M + LS1 + LDV + LS2;
  localparam int LTOT = DR + 1;

  logic signed [CB-1:0] center_x_r;
  logic signed [CB-1:0] center_y_r;
  logic [CB-2:0]        radius_r;
  logic [EB-1:0]        epsilon_r;

  logic ce;
  assign ce        = !out_valid || out_ready;
  assign in_ready  = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
      epsilon_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        scim_pkg::REG_CENTER_X: center_x_r <= cfg_wdata[CB-1:0];
        scim_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata[CB-1:0];
        scim_pkg::REG_RADIUS:   radius_r   <= cfg_wdata[CB-2:0];
        scim_pkg::REG_EPSILON:  epsilon_r  <= cfg_wdata[EB-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: relative start point, direction, zero-length check.
  logic signed [P-1:0] p1x_r, p1y_r, vx_r, vy_r;
  logic                degen_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      p1x_r   <= {in_start_x[CB-1], in_start_x} - {center_x_r[CB-1], center_x_r};
      p1y_r   <= {in_start_y[CB-1], in_start_y} - {center_y_r[CB-1], center_y_r};
      vx_r    <= {in_end_x[CB-1], in_end_x} - {in_start_x[CB-1], in_start_x};
      vy_r    <= {in_end_y[CB-1], in_end_y} - {in_start_y[CB-1], in_start_y};
      degen_r <= (in_end_x == in_start_x) && (in_end_y == in_start_y);
    end
  end

  logic signed [2*P-1:0]  vxx, vyy, pxvx, pyvy, pxx, pyy;
  logic signed [2*CB-1:0] rr;
  logic signed [CB-1:0]   rad_s;
  assign rad_s = {1'b0, radius_r};

  scim_mul #(.AW(P), .BW(P)) u_mul_vxx (.clk, .ce, .a(vx_r), .b(vx_r), .p(vxx));
  scim_mul #(.AW(P), .BW(P)) u_mul_vyy (.clk, .ce, .a(vy_r), .b(vy_r), .p(vyy));
  scim_mul #(.AW(P), .BW(P)) u_mul_pxvx (.clk, .ce, .a(p1x_r), .b(vx_r), .p(pxvx));
  scim_mul #(.AW(P), .BW(P)) u_mul_pyvy (.clk, .ce, .a(p1y_r), .b(vy_r), .p(pyvy));
  scim_mul #(.AW(P), .BW(P)) u_mul_pxx (.clk, .ce, .a(p1x_r), .b(p1x_r), .p(pxx));
  scim_mul #(.AW(P), .BW(P)) u_mul_pyy (.clk, .ce, .a(p1y_r), .b(p1y_r), .p(pyy));
  scim_mul #(.AW(CB), .BW(CB)) u_mul_rr (.clk, .ce, .a(rad_s), .b(rad_s), .p(rr));

  // Quadratic coefficients.
  logic [VVW-1:0]       vv_r;
  logic signed [DW-1:0] dot_r, pmr_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      vv_r  <= vxx[VVW-1:0] + vyy[VVW-1:0];
      dot_r <= pxvx + pyvy;
      pmr_r <= pxx + pyy - {{2{rr[2*CB-1]}}, rr};
    end
  end

  logic signed [QW-1:0] dd, vp;
  logic signed [DW-1:0] vv_s;
  assign vv_s = {1'b0, vv_r};

  scim_mul #(.AW(DW), .BW(DW)) u_mul_dd (.clk, .ce, .a(dot_r), .b(dot_r), .p(dd));
  scim_mul #(.AW(DW), .BW(DW)) u_mul_vp (.clk, .ce, .a(vv_s), .b(pmr_r), .p(vp));

  logic signed [QW-1:0] q_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      q_r <= dd - vp;
    end
  end

  // Snap a small discriminant to zero and flag a negative one.
  logic [QW-1:0]   qmag;
  logic            qsmall;
  logic [QW-2:0]   qs_r;
  logic            neg_r;
  assign qmag   = q_r[QW-1] ? (~q_r + QW'(1)) : q_r;
  assign qsmall = {qmag, 2'b00} < (QW+2)'(epsilon_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      qs_r  <= (qsmall || q_r[QW-1]) ? '0 : q_r[QW-2:0];
      neg_r <= !qsmall && q_r[QW-1];
    end
  end

  logic [LS1-1:0] droot;
  scim_isqrt #(.IW(QW-1), .RW(LS1)) u_sqrt_disc (.clk, .ce, .x(qs_r), .root(droot));

  logic signed [DW-1:0] dot_d;
  logic [VVW-1:0]       vv_d;
  logic                 neg_d, degen_d;

  scim_delay #(.W(DW), .D(2 + M + LS1)) u_dly_dot (
    .clk, .rst_n, .ce, .d(dot_r), .q(dot_d));
  scim_delay #(.W(VVW), .D(3 + M + LS1)) u_dly_vv (
    .clk, .rst_n, .ce, .d(vv_r), .q(vv_d));
  scim_delay #(.W(1), .D(1 + LS1)) u_dly_neg (
    .clk, .rst_n, .ce, .d(neg_r), .q(neg_d));
  scim_delay #(.W(1), .D(4 + 2 * M + LS1)) u_dly_degen_a (
    .clk, .rst_n, .ce, .d(degen_r), .q(degen_d));

  // Numerators of both roots.
  logic signed [NW-1:0] ndot;
  logic signed [NW-1:0] n1_r, n2_r;
  assign ndot = -{{(NW-DW){dot_d[DW-1]}}, dot_d};

  always_ff @(posedge clk) begin
    if (ce) begin
      n1_r <= ndot + NW'(droot);
      n2_r <= ndot - NW'(droot);
    end
  end

  // Keep the nearer root that lies on the segment.
  logic           c1, c2;
  logic [VVW-1:0] n_r, vv_e_r;
  logic           hitp_r;
  assign c1 = !n1_r[NW-1] && (n1_r[NW-2:0] <= (NW-1)'(vv_d));
  assign c2 = !n2_r[NW-1] && (n2_r[NW-2:0] <= (NW-1)'(vv_d));

  always_ff @(posedge clk) begin
    if (ce) begin
      n_r    <= c2 ? n2_r[VVW-1:0] : n1_r[VVW-1:0];
      vv_e_r <= vv_d;
      hitp_r <= !neg_d && !degen_d && (c1 || c2);
    end
  end

  logic signed [VVW:0]       n_s;
  logic signed [2*VVW+1:0]   nn;
  assign n_s = {1'b0, n_r};
  scim_mul #(.AW(VVW+1), .BW(VVW+1)) u_mul_nn (.clk, .ce, .a(n_s), .b(n_s), .p(nn));

  logic [VVW-1:0] vv_f;
  scim_delay #(.W(VVW), .D(M)) u_dly_vv_div (
    .clk, .rst_n, .ce, .d(vv_e_r), .q(vv_f));

  logic [VVW-1:0] quo;
  scim_div #(.QW(VVW)) u_div (.clk, .ce, .num(nn[2*VVW-1:0]), .den(vv_f), .quo(quo));

  logic [LS2-1:0] dist_root;
  scim_isqrt #(.IW(VVW), .RW(LS2)) u_sqrt_dist (.clk, .ce, .x(quo), .root(dist_root));

  logic hit_d, degen_o, vld_o;
  scim_delay #(.W(1), .D(M + LDV + LS2)) u_dly_hit (
    .clk, .rst_n, .ce, .d(hitp_r), .q(hit_d));
  scim_delay #(.W(1), .D(DR - 1)) u_dly_degen_b (
    .clk, .rst_n, .ce, .d(degen_r), .q(degen_o));
  scim_delay #(.W(1), .D(LTOT - 1)) u_dly_valid (
    .clk, .rst_n, .ce, .d(in_valid), .q(vld_o));

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [CB-1:0]        out_hit_distance_r;
  logic                 out_degenerate_r;
  logic [CB-1:0]        dist_sat;
  assign dist_sat = dist_root[CB] ? '1 : dist_root[CB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r        <= 1'b0;
      out_hit_r          <= 1'b0;
      out_hit_distance_r <= '0;
      out_degenerate_r   <= 1'b0;
    end else if (ce) begin
      out_valid_r        <= vld_o;
      out_hit_r          <= hit_d;
      out_hit_distance_r <= hit_d ? dist_sat : '1;
      out_degenerate_r   <= degen_o;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_hit_distance_r;
  assign out_degenerate   = out_degenerate_r;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } segment_t;

  typedef struct {
    logic        hit;
    logic [31:0] distance;
    logic        degen;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic signed [31:0] in_end_x = '0;
  logic signed [31:0] in_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [31:0] out_hit_distance;
  logic out_degenerate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic signed [31:0] center_x_q = '0;
  logic signed [31:0] center_y_q = '0;
  logic [30:0] radius_q = '0;
  logic [31:0] epsilon_q = '0;

  segment_t pending_segs[$];
  crossing_t expected_crossings[$];
  int mismatches = 0;
  int results_seen = 0;
  int hits_seen = 0;
  bit calm = 1'b0;
  bit running = 1'b1;
  bit in_accepted = 1'b0;

  segment_circle_intersect_unit dut (.*);

  always #4 clk = ~clk;

  function automatic crossing_t predict_crossing(segment_t s);
    logic signed [255:0] sx, sy, ex, ey, p1x, p1y, vx, vy, vv, dot, pp, rr, rw, q, disc, mag;
    logic signed [255:0] d, n1, n2, n;
    logic [255:0] c, dist_v;
    crossing_t r;
    r.hit = 1'b0;
    r.distance = '1;
    r.degen = 1'b0;
    if (s.sx == s.ex && s.sy == s.ey) begin
      r.degen = 1'b1;
      return r;
    end
    sx = s.sx;
    sy = s.sy;
    ex = s.ex;
    ey = s.ey;
    p1x = sx - 256'(signed'(center_x_q));
    p1y = sy - 256'(signed'(center_y_q));
    vx = ex - sx;
    vy = ey - sy;
    rw = {225'd0, radius_q};
    vv = vx * vx + vy * vy;
    dot = p1x * vx + p1y * vy;
    pp = p1x * p1x + p1y * p1y;
    rr = rw * rw;
    q = dot * dot - vv * (pp - rr);
    disc = q * 4;
    mag = (disc < 0) ? -disc : disc;
    if ($unsigned(mag) < {224'd0, epsilon_q}) q = 0;
    if (q < 0) return r;
    d = 0;
    for (int b = 127; b >= 0; b--) begin
      c = $unsigned(d) | (256'd1 << b);
      if (c * c <= $unsigned(q)) d = c;
    end
    n1 = -dot + d;
    n2 = -dot - d;
    if (n2 >= 0 && n2 <= vv) n = n2;
    else if (n1 >= 0 && n1 <= vv) n = n1;
    else return r;
    dist_v = 0;
    for (int b = 63; b >= 0; b--) begin
      c = dist_v | (256'd1 << b);
      if (c * c * $unsigned(vv) <= $unsigned(n * n)) dist_v = c;
    end
    r.hit = 1'b1;
    r.distance = (dist_v[255:32] != 0) ? 32'hFFFF_FFFF : dist_v[31:0];
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_accepted)) begin
      if (pending_segs.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
        in_start_x <= pending_segs[0].sx;
        in_start_y <= pending_segs[0].sy;
        in_end_x <= pending_segs[0].ex;
        in_end_y <= pending_segs[0].ey;
        in_valid <= 1'b1;
        void'(pending_segs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && (calm || $urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    segment_t s;
    crossing_t want;
    in_accepted = rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      s.sx = in_start_x;
      s.sy = in_start_y;
      s.ex = in_end_x;
      s.ey = in_end_y;
      expected_crossings.push_back(predict_crossing(s));
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      hits_seen += out_hit;
      if (expected_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item at %0t", $time);
      end else begin
        want = expected_crossings.pop_front();
        if (out_hit !== want.hit || out_hit_distance !== want.distance ||
            out_degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected hit=%0d dist=%h degen=%0d, got %0d %h %0d",
                     $time, want.hit, want.distance, want.degen,
                     out_hit, out_hit_distance, out_degenerate);
        end
      end
    end
  end

  task automatic write_reg(scim_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      scim_pkg::REG_CENTER_X: center_x_q = val;
      scim_pkg::REG_CENTER_Y: center_y_q = val;
      scim_pkg::REG_RADIUS: radius_q = val[30:0];
      default: epsilon_q = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [31:0] rad,
                            logic [31:0] eps);
    write_reg(scim_pkg::REG_CENTER_X, cx);
    write_reg(scim_pkg::REG_CENTER_Y, cy);
    write_reg(scim_pkg::REG_RADIUS, rad);
    write_reg(scim_pkg::REG_EPSILON, eps);
  endtask

  task automatic add_seg(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
    segment_t s;
    s.sx = sx;
    s.sy = sy;
    s.ex = ex;
    s.ey = ey;
    pending_segs.push_back(s);
  endtask

  task automatic drain();
    while (pending_segs.size() != 0 || expected_crossings.size() != 0 || in_valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord(logic [31:0] base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic add_random(int count, int span);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 75)
        add_seg(near_coord(center_x_q, span), near_coord(center_y_q, span),
                near_coord(center_x_q, span), near_coord(center_y_q, span));
      else if (kind < 85)
        add_seg($urandom, $urandom, $urandom, $urandom);
      else if (kind < 92) begin
        add_seg(near_coord(center_x_q, span), near_coord(center_y_q, span), 0, 0);
        pending_segs[$].ex = pending_segs[$].sx;
        pending_segs[$].ey = pending_segs[$].sy;
      end else
        add_seg(near_coord(center_x_q, 4), near_coord(center_y_q, span),
                near_coord(center_x_q, 4), near_coord(center_y_q, span));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unit circle at the origin: crossings, misses, tangents and degenerate segments.
    set_circle(0, 0, 32'h0001_0000, 0);
    add_seg(32'hFFFE_0000, 0, 32'h0002_0000, 0);
    add_seg(32'hFFFE_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    add_seg(32'hFFFE_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    add_seg(0, 0, 32'h0000_4000, 0);
    add_seg(0, 0, 32'h0003_0000, 0);
    add_seg(32'h0003_0000, 0, 32'h0005_0000, 0);
    add_seg(32'h0005_0000, 0, 32'h0003_0000, 0);
    add_seg(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
    add_seg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_seg(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
    add_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    add_random(60, 32'h0003_0000);
    drain();

    // Near-tangent lines with a wide snapping threshold.
    set_circle(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    add_seg(32'hFFFF_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
    add_seg(32'hFFFF_0000, 32'h0000_0001, 32'h0003_0000, 32'h0000_0001);
    add_seg(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFF_FFFF);
    add_random(150, 32'h0002_0000);
    drain();

    // Extreme registers: far corner center, largest radius, saturated distances.
    set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    add_seg(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_seg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_seg(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_random(150, 32'h7FFF_FFFF);
    drain();

    set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0);
    add_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_random(100, 8);
    drain();

    calm = 1'b1;
    set_circle($urandom, $urandom, $urandom_range(0, 32'h0020_0000), $urandom_range(0, 1000));
    add_random(200, int'(radius_q) * 2 + 16);
    drain();
    calm = 1'b0;

    for (int p = 0; p < 4; p++) begin
      set_circle($urandom, $urandom, $urandom_range(1, 32'h0100_0000),
                 (p == 0) ? 0 : $urandom_range(0, 32'h0001_0000));
      add_random(120, int'(radius_q) * 2 + 16);
      drain();
    end

    $display("Covered %0d segment queries over nine circle settings, %0d of them hits.",
             results_seen, hits_seen);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
